>>> rtl/core/tpbm_pkg.sv
// Shared types and constants for the tilt PD balance mixer.
// No dependencies; every other file of the block imports this package.
package tpbm_pkg;

  // Field widths
  localparam int TILT_W     = 17;
  localparam int GAIN_W     = 16;
  localparam int CORR_W     = GAIN_W + 1;
  localparam int OFFSET_W   = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Fixed-point scaling: P term is lifted by 2^8 to meet the 2^24 scale of the D term,
  // and the correction is rounded back to Q8.8 by dropping 16 bits.
  localparam int PTERM_SHIFT = 8;
  localparam int FRAC_W      = 16;
  localparam int ROUND_HALF  = 32768;

  localparam int TICK_RATE_HZ_DEF = 50;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_KP       = 3'd1,
    CFG_KD       = 3'd2,
    CFG_DEADBAND = 3'd3,
    CFG_MAX_CORR = 3'd4
  } tpbm_cfg_idx_t;

  // Register values used by each axis pipe
  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] kd;
    logic [GAIN_W-1:0] deadband;
    logic [GAIN_W-1:0] max_corr;
  } tpbm_cfg_t;

  // Per-stage load enables of the pipeline
  typedef struct packed {
    logic ld0;
    logic ld1;
    logic ld2;
    logic ld3;
  } tpbm_adv_t;

endpackage

>>> rtl/core/tpbm_if.sv
// Valid/ready channel interfaces for the tilt PD balance mixer.
// Depends on tpbm_pkg for the field widths.
interface tpbm_in_if import tpbm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     held;
  logic signed [TILT_W-1:0] pitch_tilt;
  logic signed [TILT_W-1:0] roll_tilt;

  modport source (output valid, held, pitch_tilt, roll_tilt, input ready);
  modport sink   (input valid, held, pitch_tilt, roll_tilt, output ready);
endinterface

interface tpbm_out_if import tpbm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OFFSET_W-1:0] front_left_offset;
  logic signed [OFFSET_W-1:0] front_right_offset;
  logic signed [OFFSET_W-1:0] back_left_offset;
  logic signed [OFFSET_W-1:0] back_right_offset;

  modport source (output valid, front_left_offset, front_right_offset,
                  back_left_offset, back_right_offset, input ready);
  modport sink   (input valid, front_left_offset, front_right_offset,
                  back_left_offset, back_right_offset, output ready);
endinterface

>>> rtl/core/tpbm_axis.sv
// One axis of the PD controller: deadband, difference, P and D products,
// rounding and clamp, as a four-register pipeline. Depends on tpbm_pkg.
module tpbm_axis import tpbm_pkg::*; #(
  parameter int TICK_RATE_HZ = TICK_RATE_HZ_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tpbm_adv_t                adv,
  input  logic                     active,
  input  logic signed [TILT_W-1:0] tilt,
  input  tpbm_cfg_t                cfg,
  output logic signed [CORR_W-1:0] corr
);

  localparam int DIFF_W  = TILT_W + 1;
  localparam int TICK_W  = $clog2(TICK_RATE_HZ + 1) + 1;
  localparam int RATE_W  = DIFF_W + TICK_W;
  localparam int DPROD_W = RATE_W + GAIN_W + 1;
  localparam int PPROD_W = TILT_W + GAIN_W + 1;
  localparam int PTERM_W = PPROD_W + PTERM_SHIFT;
  localparam int SUM_W   = ((PTERM_W > DPROD_W) ? PTERM_W : DPROD_W) + 3;
  localparam int C_W     = SUM_W - FRAC_W;
  localparam logic signed [TICK_W-1:0] TICK_S = TICK_W'(TICK_RATE_HZ);

  logic signed [TILT_W-1:0]  prev_r, prev_nxt;
  logic signed [TILT_W-1:0]  v_r, v_nxt;
  logic signed [DIFF_W-1:0]  d_r, d_nxt;
  logic signed [RATE_W-1:0]  rate_r, rate_nxt;
  logic signed [PPROD_W-1:0] pprod_r, pprod_nxt;
  logic signed [PPROD_W-1:0] pterm_r;
  logic signed [DPROD_W-1:0] dprod_r, dprod_nxt;
  logic signed [CORR_W-1:0]  corr_r, corr_nxt;

  logic signed [DIFF_W-1:0]  tilt_x;
  logic        [TILT_W-1:0]  mag;
  logic signed [SUM_W-1:0]   sum, rnd;
  logic signed [C_W-1:0]     c, lim;

  // Deadband and difference against the previous kept value;
  // an inactive tick carries no difference, so its correction is zero
  always_comb begin
    tilt_x   = DIFF_W'(tilt);
    mag      = tilt_x[DIFF_W-1] ? TILT_W'(-tilt_x) : TILT_W'(tilt_x);
    v_nxt    = (active && (mag >= TILT_W'(cfg.deadband))) ? tilt : '0;
    d_nxt    = active ? (DIFF_W'(v_nxt) - DIFF_W'(prev_r)) : '0;
    prev_nxt = v_nxt;
  end

  // Previous value advances on every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (adv.ld0) begin
      prev_r <= prev_nxt;
    end
  end

  // Stage products
  always_comb begin
    rate_nxt  = RATE_W'(d_r) * RATE_W'(TICK_S);
    pprod_nxt = PPROD_W'(v_r) * PPROD_W'($signed({1'b0, cfg.kp}));
    dprod_nxt = DPROD_W'(rate_r) * DPROD_W'($signed({1'b0, cfg.kd}));
  end

  // Negate, round to nearest Q8.8 and clamp
  always_comb begin
    sum = (SUM_W'(pterm_r) <<< PTERM_SHIFT) + SUM_W'(dprod_r);
    rnd = -sum + SUM_W'(ROUND_HALF);
    c   = rnd[SUM_W-1:FRAC_W];
    lim = C_W'($signed({1'b0, cfg.max_corr}));
    if (c > lim) begin
      corr_nxt = CORR_W'(lim);
    end else if (c < -lim) begin
      corr_nxt = CORR_W'(-lim);
    end else begin
      corr_nxt = CORR_W'(c);
    end
  end

  // Pipeline payload registers
  always_ff @(posedge clk) begin
    if (adv.ld0) begin
      v_r <= v_nxt;
      d_r <= d_nxt;
    end
    if (adv.ld1) begin
      rate_r  <= rate_nxt;
      pprod_r <= pprod_nxt;
    end
    if (adv.ld2) begin
      dprod_r <= dprod_nxt;
      pterm_r <= pprod_r;
    end
    if (adv.ld3) begin
      corr_r <= corr_nxt;
    end
  end

  assign corr = corr_r;

endmodule

>>> rtl/core/tpbm_mixer.sv
// Mixes pitch and roll corrections into the four hip offsets.
// Depends on tpbm_pkg for widths.
module tpbm_mixer import tpbm_pkg::*; (
  input  logic signed [CORR_W-1:0]   pitch_adj,
  input  logic signed [CORR_W-1:0]   roll_adj,
  output logic signed [OFFSET_W-1:0] front_left,
  output logic signed [OFFSET_W-1:0] front_right,
  output logic signed [OFFSET_W-1:0] back_left,
  output logic signed [OFFSET_W-1:0] back_right
);

  logic signed [OFFSET_W-1:0] pc, rc;

  // Sum and difference of the two axes
  always_comb begin
    pc          = OFFSET_W'(pitch_adj);
    rc          = OFFSET_W'(roll_adj);
    front_left  = pc - rc;
    front_right = pc + rc;
    back_left   = -pc - rc;
    back_right  = -pc + rc;
  end

endmodule

>>> rtl/core/tilt_pd_balance_mixer_top.sv
// Tilt PD balance mixer: two axis pipes, mixer and output register.
// A result is valid once its transaction has passed the axis pipe stages and the output register.
// Throughput: one transaction per cycle; a stage holds while the next is full and stalled.
// Reset (synchronous, rst_n low): config registers, previous tilts and valid bits clear.
// Depends on tpbm_pkg, tpbm_if, tpbm_axis and tpbm_mixer.
module tilt_pd_balance_mixer_top import tpbm_pkg::*; #(
  parameter int TICK_RATE_HZ = TICK_RATE_HZ_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tpbm_in_if.sink               in_ch,
  tpbm_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic       enable_r;
  tpbm_cfg_t  cfg_r;
  logic [3:0] vld_r, vld_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic [4:0] rdy;
  logic       ld_out;
  tpbm_adv_t  adv;

  logic signed [CORR_W-1:0]   pitch_adj, roll_adj;
  logic signed [OFFSET_W-1:0] fl, fr, bl, br;
  logic signed [OFFSET_W-1:0] fl_r, fr_r, bl_r, br_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      cfg_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:   enable_r       <= cfg_data[0];
        CFG_KP:       cfg_r.kp       <= cfg_data;
        CFG_KD:       cfg_r.kd       <= cfg_data;
        CFG_DEADBAND: cfg_r.deadband <= cfg_data;
        CFG_MAX_CORR: cfg_r.max_corr <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Per-stage ready chain and load enables
  always_comb begin
    rdy[4]   = !out_vld_r || out_ch.ready;
    rdy[3]   = !vld_r[3] || rdy[4];
    rdy[2]   = !vld_r[2] || rdy[3];
    rdy[1]   = !vld_r[1] || rdy[2];
    rdy[0]   = !vld_r[0] || rdy[1];
    adv.ld0  = in_ch.valid && rdy[0];
    adv.ld1  = vld_r[0] && rdy[1];
    adv.ld2  = vld_r[1] && rdy[2];
    adv.ld3  = vld_r[2] && rdy[3];
    ld_out   = vld_r[3] && rdy[4];
    vld_nxt[0]  = adv.ld0 || (vld_r[0] && !adv.ld1);
    vld_nxt[1]  = adv.ld1 || (vld_r[1] && !adv.ld2);
    vld_nxt[2]  = adv.ld2 || (vld_r[2] && !adv.ld3);
    vld_nxt[3]  = adv.ld3 || (vld_r[3] && !ld_out);
    out_vld_nxt = ld_out || (out_vld_r && !out_ch.ready);
  end

  assign in_ch.ready = rdy[0];

  // Hold stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  tpbm_axis #(.TICK_RATE_HZ(TICK_RATE_HZ)) u_pitch (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .active (enable_r && !in_ch.held),
    .tilt   (in_ch.pitch_tilt),
    .cfg    (cfg_r),
    .corr   (pitch_adj)
  );

  tpbm_axis #(.TICK_RATE_HZ(TICK_RATE_HZ)) u_roll (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .active (enable_r && !in_ch.held),
    .tilt   (in_ch.roll_tilt),
    .cfg    (cfg_r),
    .corr   (roll_adj)
  );

  tpbm_mixer u_mixer (
    .pitch_adj   (pitch_adj),
    .roll_adj    (roll_adj),
    .front_left  (fl),
    .front_right (fr),
    .back_left   (bl),
    .back_right  (br)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (ld_out) begin
      fl_r <= fl;
      fr_r <= fr;
      bl_r <= bl;
      br_r <= br;
    end
  end

  assign out_ch.valid              = out_vld_r;
  assign out_ch.front_left_offset  = fl_r;
  assign out_ch.front_right_offset = fr_r;
  assign out_ch.back_left_offset   = bl_r;
  assign out_ch.back_right_offset  = br_r;

  // An accepted transaction always lands in the first stage
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted transaction not captured in first stage");

  // Diagonal offsets are exact negatives of each other
  a_mix_symmetry: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((fl_r + br_r) == '0) && ((fr_r + bl_r) == '0))
    else $error("hip offsets lost their mixing symmetry");

  // A full output stage that is not drained blocks the last pipeline stage
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready && vld_r[3] |=> vld_r[3] && out_vld_r)
    else $error("result dropped while output stalled");

endmodule

>>> dv/tpbm_balance_checker.sv
// Checker for the tilt PD balance mixer: watches both channels and the config port.
// Predicts the four hip offsets of every accepted tick and compares the results in order.
// Depends on tpbm_pkg and the tpbm_in_if / tpbm_out_if interfaces.
`timescale 1ns / 1ps

module tpbm_balance_checker import tpbm_pkg::*; #(
  parameter int TICK_RATE = TICK_RATE_HZ_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tpbm_in_if                    in_mon,
  tpbm_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    error_count,
  output int                    outstanding
);

  typedef struct packed {
    logic signed [OFFSET_W-1:0] front_left;
    logic signed [OFFSET_W-1:0] front_right;
    logic signed [OFFSET_W-1:0] back_left;
    logic signed [OFFSET_W-1:0] back_right;
  } hip_offsets_t;

  // Shadow copy of the block's registers and previous kept tilts
  logic                     balance_en;
  tpbm_cfg_t                gains;
  logic signed [TILT_W-1:0] last_pitch;
  logic signed [TILT_W-1:0] last_roll;

  hip_offsets_t expected_offsets[$];

  // Zero a tilt whose magnitude is strictly below the deadband
  function automatic logic signed [TILT_W-1:0] apply_deadband(
    input logic signed [TILT_W-1:0] tilt
  );
    int t;
    int mag;
    t   = int'(tilt);
    mag = (t < 0) ? -t : t;
    return (mag < int'(gains.deadband)) ? '0 : tilt;
  endfunction

  // Minus (P + D) at scale 2^24, rounded half up to Q8.8, then clamped
  function automatic longint axis_correction(
    input logic signed [TILT_W-1:0] kept,
    input logic signed [TILT_W-1:0] prev
  );
    longint rate;
    longint sum;
    longint corr;
    longint lim;
    rate = (longint'(kept) - longint'(prev)) * longint'(TICK_RATE);
    sum  = longint'(kept) * longint'(gains.kp) * (longint'(1) <<< PTERM_SHIFT)
         + rate * longint'(gains.kd);
    corr = (longint'(ROUND_HALF) - sum) >>> FRAC_W;
    lim  = longint'(gains.max_corr);
    if (corr > lim) corr = lim;
    if (corr < -lim) corr = -lim;
    return corr;
  endfunction

  task automatic check_field(
    input string                      name,
    input logic signed [OFFSET_W-1:0] want,
    input logic signed [OFFSET_W-1:0] got
  );
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Track config writes, predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    hip_offsets_t             want;
    logic signed [TILT_W-1:0] kept_pitch;
    logic signed [TILT_W-1:0] kept_roll;
    longint                   pitch_adj;
    longint                   roll_adj;
    if (!rst_n) begin
      balance_en  = 1'b0;
      gains       = '0;
      last_pitch  = '0;
      last_roll   = '0;
      error_count = 0;
      expected_offsets.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:   balance_en = cfg_data[0];
          CFG_KP:       gains.kp = cfg_data;
          CFG_KD:       gains.kd = cfg_data;
          CFG_DEADBAND: gains.deadband = cfg_data;
          CFG_MAX_CORR: gains.max_corr = cfg_data;
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        want = '0;
        if (balance_en && !in_mon.held) begin
          kept_pitch = apply_deadband(in_mon.pitch_tilt);
          kept_roll  = apply_deadband(in_mon.roll_tilt);
          pitch_adj  = axis_correction(kept_pitch, last_pitch);
          roll_adj   = axis_correction(kept_roll, last_roll);
          last_pitch = kept_pitch;
          last_roll  = kept_roll;
          want.front_left  = OFFSET_W'(pitch_adj - roll_adj);
          want.front_right = OFFSET_W'(pitch_adj + roll_adj);
          want.back_left   = OFFSET_W'(-pitch_adj - roll_adj);
          want.back_right  = OFFSET_W'(-pitch_adj + roll_adj);
        end else begin
          // Disabled or held: offsets stay zero, history is dropped
          last_pitch = '0;
          last_roll  = '0;
        end
        expected_offsets.push_back(want);
      end

      if (out_mon.valid && out_mon.ready) begin
        if (expected_offsets.size() == 0) begin
          $error("output transaction with no prediction pending");
          error_count++;
        end else begin
          want = expected_offsets.pop_front();
          check_field("front_left_offset", want.front_left, out_mon.front_left_offset);
          check_field("front_right_offset", want.front_right, out_mon.front_right_offset);
          check_field("back_left_offset", want.back_left, out_mon.back_left_offset);
          check_field("back_right_offset", want.back_right, out_mon.back_right_offset);
        end
      end
    end
    outstanding = expected_offsets.size();
  end

endmodule

>>> dv/tb.sv
// Testbench top for the tilt PD balance mixer: clock, reset, stimulus and verdict.
// Drives ticks with bursty valid and a stalling receiver; tpbm_balance_checker does the checks.
// Depends on tpbm_pkg, tpbm_if, tilt_pd_balance_mixer_top and tpbm_balance_checker.
`timescale 1ns / 1ps

module tb;
  import tpbm_pkg::*;

  localparam int TICK_RATE       = TICK_RATE_HZ_DEF;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int HOLD_OFF_PHASE  = 2;
  localparam int DISABLED_PHASE  = 5;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int TILT_MAX        = 46080;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   error_count;
  int   outstanding;
  int   burst_left;
  int   cycle_count;
  logic hold_off_req;

  // Random walk state for well-formed tilt sequences
  int walk_pitch;
  int walk_roll;
  int walk_step;
  int pick;
  logic [CFG_DATA_W-1:0] enable_word;

  tpbm_in_if  in_ch ();
  tpbm_out_if out_ch ();

  tilt_pd_balance_mixer_top #(
    .TICK_RATE_HZ(TICK_RATE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  tpbm_balance_checker #(
    .TICK_RATE(TICK_RATE)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .error_count(error_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Timeout guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: a random stall pattern, redrawn when its run is spent, plus one long hold-off
  initial begin
    int mode;
    int mode_left;
    int held_cycles;
    mode      = 0;
    mode_left = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        held_cycles = 1;
        while (held_cycles < HOLD_OFF_CYCLES) begin
          @(negedge clk);
          held_cycles++;
        end
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= ($urandom_range(0, 9) < 3);
          default: out_ch.ready <= (mode_left % 5 != 0);
        endcase
      end
    end
  end

  // Offer one tick; open a new burst after a random gap when the current one is spent
  task automatic send_tilt(
    input logic                     held,
    input logic signed [TILT_W-1:0] pitch,
    input logic signed [TILT_W-1:0] roll
  );
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.held       <= held;
    in_ch.pitch_tilt <= pitch;
    in_ch.roll_tilt  <= roll;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  // Drop valid, wait for every prediction to be matched, then let the pipe settle
  task automatic drain_and_settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(
    input logic [CFG_IDX_W-1:0]  idx,
    input logic [CFG_DATA_W-1:0] data
  );
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Write every index beyond the register list; the block must ignore them
  task automatic poke_unused_regs();
    for (int k = int'(CFG_MAX_CORR) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return CFG_DATA_W'($urandom_range(0, 1024));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'(TILT_MAX);
      3:       return CFG_DATA_W'($urandom_range(0, 1024));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic int clamp_tilt(input int v);
    if (v > TILT_MAX) return TILT_MAX;
    if (v < -TILT_MAX) return -TILT_MAX;
    return v;
  endfunction

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.held       = 1'b0;
    in_ch.pitch_tilt = '0;
    in_ch.roll_tilt  = '0;
    hold_off_req     = 1'b0;
    burst_left       = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: correction is off, every offset must be zero
    send_tilt(1'b0, 17'sd12800, -17'sd12800);
    send_tilt(1'b1, -17'sd3000, 17'sd500);
    send_tilt(1'b0, 17'sd46080, 17'sd46080);
    drain_and_settle();

    // Unit proportional gain, modest derivative gain, one degree deadband
    write_reg(CFG_ENABLE, 16'h0001);
    write_reg(CFG_KP, 16'h0100);
    write_reg(CFG_KD, 16'h2000);
    write_reg(CFG_DEADBAND, 16'h0100);
    write_reg(CFG_MAX_CORR, 16'(TILT_MAX));
    poke_unused_regs();
    send_tilt(1'b0, 17'sd0, 17'sd0);
    send_tilt(1'b0, 17'sd46080, -17'sd46080);
    send_tilt(1'b0, -17'sd46080, 17'sd46080);
    send_tilt(1'b0, -17'sd65536, 17'sd65535);
    send_tilt(1'b0, 17'sd65535, -17'sd65536);
    send_tilt(1'b0, 17'sd255, -17'sd255);
    send_tilt(1'b0, 17'sd256, -17'sd256);
    send_tilt(1'b0, 17'sd257, 17'sd0);
    send_tilt(1'b1, 17'sd1000, 17'sd1000);
    send_tilt(1'b0, 17'sd1000, -17'sd1000);
    send_tilt(1'b0, 17'sd1000, -17'sd1000);
    drain_and_settle();

    // Zero clamp limit forces both corrections to zero
    write_reg(CFG_MAX_CORR, 16'h0000);
    send_tilt(1'b0, 17'sd20000, -17'sd7000);
    send_tilt(1'b0, -17'sd30000, 17'sd9000);
    drain_and_settle();

    // Largest gains and clamp with no deadband, then the largest deadband
    write_reg(CFG_KP, 16'hFFFF);
    write_reg(CFG_KD, 16'hFFFF);
    write_reg(CFG_DEADBAND, 16'h0000);
    write_reg(CFG_MAX_CORR, 16'hFFFF);
    send_tilt(1'b0, 17'sd1, -17'sd1);
    send_tilt(1'b0, -17'sd65536, 17'sd65535);
    send_tilt(1'b0, 17'sd65535, -17'sd65536);
    drain_and_settle();
    write_reg(CFG_DEADBAND, 16'hFFFF);
    send_tilt(1'b0, 17'sd65535, -17'sd65536);
    send_tilt(1'b0, -17'sd65536, 17'sd40000);
    drain_and_settle();

    // Only bit 0 of the enable word counts
    write_reg(CFG_ENABLE, 16'hFFFE);
    send_tilt(1'b0, 17'sd30000, 17'sd30000);
    drain_and_settle();
    write_reg(CFG_ENABLE, 16'hFFFF);
    send_tilt(1'b0, 17'sd30000, 17'sd30000);

    // Random phases: fresh settings, then mostly smooth tilt walks with held ticks and noise
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_and_settle();
      enable_word    = CFG_DATA_W'($urandom);
      enable_word[0] = (ph != DISABLED_PHASE);
      write_reg(CFG_ENABLE, enable_word);
      write_reg(CFG_KP, pick_gain());
      write_reg(CFG_KD, pick_gain());
      write_reg(CFG_DEADBAND, ($urandom_range(0, 2) == 0) ? pick_limit()
                                                         : CFG_DATA_W'($urandom_range(0, 512)));
      write_reg(CFG_MAX_CORR, pick_limit());
      if ($urandom_range(0, 1) == 0) poke_unused_regs();
      if (ph == HOLD_OFF_PHASE) hold_off_req = 1'b1;
      walk_pitch = int'($urandom_range(0, 2 * TILT_MAX)) - TILT_MAX;
      walk_roll  = int'($urandom_range(0, 2 * TILT_MAX)) - TILT_MAX;
      walk_step  = $urandom_range(16, 4096);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_tilt(1'b1, TILT_W'(walk_pitch), TILT_W'(walk_roll));
        end else if (pick < 16) begin
          send_tilt(1'($urandom), TILT_W'($urandom), TILT_W'($urandom));
        end else begin
          walk_pitch = clamp_tilt(walk_pitch + int'($urandom_range(0, 2 * walk_step)) - walk_step);
          walk_roll  = clamp_tilt(walk_roll + int'($urandom_range(0, 2 * walk_step)) - walk_step);
          send_tilt(1'b0, TILT_W'(walk_pitch), TILT_W'(walk_roll));
        end
      end
    end

    drain_and_settle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
